### hdl/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types and constants of the nearest point search unit.
// ----------------------------------------------------------------------------
package nps_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int POS_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int COORD_W    = 16;
  localparam int SQ_W       = 2 * COORD_W;
  localparam int DIST_W     = 2 * COORD_W + 1;
  localparam int IDX_W      = 10;
  localparam int FRAC_W     = 8;
  localparam int ROOT_W     = 25;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 1;
  localparam int STEP_W     = $clog2(ROOT_W);

  localparam int Q_DEPTH    = 4;
  localparam int QPTR_W     = $clog2(Q_DEPTH);
  localparam int QCNT_W     = $clog2(Q_DEPTH + 1);

  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUERY_X = 2'd0,
    REG_QUERY_Y = 2'd1
  } reg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_point;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]  nearest_index;
    logic [ROOT_W-1:0] nearest_distance;
    logic              count_overflow;
  } out_word_t;

  // one finished set, waiting for its square root
  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [DIST_W-1:0] sq_dist;
    logic              ovf;
  } nps_job_t;

  typedef struct packed {
    logic          empty;
    logic [QCNT_W-1:0] count;
  } nps_qstat_t;

endpackage

### hdl/nps_fifo.sv
// ----------------------------------------------------------------------------
// nps_fifo
// Short queue of finished sets between the search front and the root back.
// ----------------------------------------------------------------------------
module nps_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  nps_pkg::nps_job_t push_job,
  input  logic              pop,
  output nps_pkg::nps_job_t pop_job,
  output nps_pkg::nps_qstat_t stat
);
  import nps_pkg::*;

  nps_job_t          mem [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  assign pop_job     = mem[rd_ptr_r];
  assign stat.count  = count_r;
  assign stat.empty  = (count_r == '0);

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != QCNT_W'(Q_DEPTH)))
    else $error("set queue written while full");

  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("set queue read while empty");

endmodule

### hdl/nps_front.sv
// ----------------------------------------------------------------------------
// nps_front
// Query registers, point intake and the running nearest point search.
// ----------------------------------------------------------------------------
module nps_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [nps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nps_pkg::COORD_W-1:0]    cfg_data,
  input  logic                           push,
  output logic                           full,
  input  nps_pkg::in_word_t              in_data,
  input  nps_pkg::nps_qstat_t            q_stat,
  output logic                           q_push,
  output nps_pkg::nps_job_t              q_job
);
  import nps_pkg::*;

  logic [COORD_W-1:0] qx_r, qy_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               ovf_r;

  // stage a: absolute differences
  logic               a_vld_r, a_last_r, a_first_r, a_ovf_r;
  logic [POS_W-1:0]   a_pos_r;
  logic [COORD_W-1:0] a_mx_r, a_my_r;

  // stage b: squares
  logic               b_vld_r, b_last_r, b_first_r, b_ovf_r;
  logic [POS_W-1:0]   b_pos_r;
  logic [SQ_W-1:0]    b_sqx_r, b_sqy_r;

  logic [DIST_W-1:0]  best_d_r, best_d_nxt;
  logic [POS_W-1:0]   best_p_r, best_p_nxt;

  logic               accept;
  logic               at_cap;
  logic               ovf_now;
  logic [POS_W-1:0]   pos_now;
  logic [COORD_W:0]   dx, dy;
  logic [COORD_W:0]   ax, ay;
  logic [DIST_W-1:0]  cur_dist;
  logic               take;
  logic [QCNT_W:0]    pending;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qx_r <= '0;
      qy_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_QUERY_X: qx_r <= cfg_data;
        REG_QUERY_Y: qy_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // room for every set end still in flight, plus the incoming word
  assign pending = {1'b0, q_stat.count} + (QCNT_W+1)'(a_vld_r & a_last_r)
                 + (QCNT_W+1)'(b_vld_r & b_last_r);
  assign full    = (pending >= (QCNT_W+1)'(Q_DEPTH));
  assign accept  = push && !full;

  assign at_cap  = (cnt_r == CNT_W'(MAX_POINTS));
  assign ovf_now = ovf_r | at_cap;
  assign pos_now = at_cap ? POS_W'(MAX_POINTS - 1) : cnt_r[POS_W-1:0];

  assign dx = {in_data.point_x[COORD_W-1], in_data.point_x} - {qx_r[COORD_W-1], qx_r};
  assign dy = {in_data.point_y[COORD_W-1], in_data.point_y} - {qy_r[COORD_W-1], qy_r};
  assign ax = dx[COORD_W] ? (~dx + (COORD_W+1)'(1)) : dx;
  assign ay = dy[COORD_W] ? (~dy + (COORD_W+1)'(1)) : dy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= accept;
      b_vld_r <= a_vld_r;
      if (accept) begin
        if (in_data.last_point) begin
          cnt_r <= '0;
          ovf_r <= 1'b0;
        end else begin
          cnt_r <= at_cap ? cnt_r : cnt_r + CNT_W'(1);
          ovf_r <= ovf_now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_last_r  <= in_data.last_point;
      a_first_r <= (cnt_r == '0);
      a_ovf_r   <= ovf_now;
      a_pos_r   <= pos_now;
      a_mx_r    <= ax[COORD_W-1:0];
      a_my_r    <= ay[COORD_W-1:0];
    end
    if (a_vld_r) begin
      b_last_r  <= a_last_r;
      b_first_r <= a_first_r;
      b_ovf_r   <= a_ovf_r;
      b_pos_r   <= a_pos_r;
      b_sqx_r   <= a_mx_r * a_mx_r;
      b_sqy_r   <= a_my_r * a_my_r;
    end
  end

  // first point of a set always wins, later ones only when strictly closer
  assign cur_dist = {1'b0, b_sqx_r} + {1'b0, b_sqy_r};
  assign take     = b_first_r || (cur_dist < best_d_r);

  always_comb begin
    best_d_nxt = best_d_r;
    best_p_nxt = best_p_r;
    if (take) begin
      best_d_nxt = cur_dist;
      best_p_nxt = b_pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_d_r <= '0;
      best_p_r <= '0;
    end else if (b_vld_r) begin
      best_d_r <= best_d_nxt;
      best_p_r <= best_p_nxt;
    end
  end

  assign q_push        = b_vld_r && b_last_r;
  assign q_job.pos     = best_p_nxt;
  assign q_job.sq_dist = best_d_nxt;
  assign q_job.ovf     = b_ovf_r;

  a_reserve: assert property (@(posedge clk) disable iff (!rst_n)
    pending <= (QCNT_W+1)'(Q_DEPTH))
    else $error("more set ends in flight than queue room");

endmodule

### hdl/nps_back.sv
// ----------------------------------------------------------------------------
// nps_back
// Digit-by-digit square root of the best distance and the result register.
// ----------------------------------------------------------------------------
module nps_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  nps_pkg::nps_qstat_t  q_stat,
  input  nps_pkg::nps_job_t    q_job,
  output logic                 q_pop,
  output logic                 empty,
  input  logic                 pop,
  output nps_pkg::out_word_t   out_data
);
  import nps_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } bk_state_t;

  bk_state_t         state_r, state_nxt;
  logic [RAD_W-1:0]  rad_r;
  logic [ROOT_W-1:0] root_r;
  logic [REM_W-1:0]  rem_r;
  logic [STEP_W-1:0] step_r;
  logic [POS_W-1:0]  pos_r;
  logic              ovf_r;
  logic              out_vld_r;
  out_word_t         out_r;

  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic              fits;
  logic              out_load;

  assign rem_sh = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign fits   = (rem_sh >= trial);

  assign q_pop    = (state_r == ST_IDLE) && !q_stat.empty;
  assign out_load = (state_r == ST_DONE) && (!out_vld_r || pop);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (q_pop) state_nxt = ST_RUN;
      ST_RUN:  if (step_r == STEP_W'(ROOT_W - 1)) state_nxt = ST_DONE;
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // radicand is the squared distance scaled by two fraction bytes
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rad_r  <= {{(RAD_W-DIST_W-2*FRAC_W){1'b0}}, q_job.sq_dist, {(2*FRAC_W){1'b0}}};
      root_r <= '0;
      rem_r  <= '0;
      step_r <= '0;
      pos_r  <= q_job.pos;
      ovf_r  <= q_job.ovf;
    end else if (state_r == ST_RUN) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      step_r <= step_r + STEP_W'(1);
      if (fits) begin
        rem_r  <= REM_W'(rem_sh - trial);
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[REM_W-1:0];
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
    if (out_load) begin
      out_r.nearest_index    <= IDX_W'(pos_r);
      out_r.nearest_distance <= root_r;
      out_r.count_overflow   <= ovf_r;
    end
  end

  assign empty    = !out_vld_r;
  assign out_data = out_r;

  a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_vld_r && !pop) |=> (state_r == ST_DONE))
    else $error("root result left while output word still waiting");

  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (step_r <= STEP_W'(ROOT_W - 1)))
    else $error("root sequencer ran past its last digit");

endmodule

### hdl/nearest_point_search_unit.sv
// ----------------------------------------------------------------------------
// nearest_point_search_unit
// Streams a set of points, finds the one nearest the query point and
// returns its position and Euclidean distance.
// ----------------------------------------------------------------------------
// Points are taken one per clock while full is low. Each point runs the front
// pipeline (difference, square, add and compare) that tracks the nearest
// point of the set. When the last point of a set has passed it, the set
// goes into a four-deep queue; the back end then takes one set at a time
// and forms the square root digit by digit, one result bit per cycle.
// Sets of many points stream at full rate; with very short sets the back
// end's root loop sets the pace, and push sees full once four set ends
// wait for it.
module nearest_point_search_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [nps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nps_pkg::COORD_W-1:0]   cfg_data,
  input  logic                          push,
  output logic                          full,
  input  nps_pkg::in_word_t             in_data,
  output logic                          empty,
  input  logic                          pop,
  output nps_pkg::out_word_t            out_data
);
  import nps_pkg::*;

  logic       q_push;
  logic       q_pop;
  nps_job_t   q_in_job;
  nps_job_t   q_out_job;
  nps_qstat_t q_stat;

  nps_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_job     (q_in_job)
  );

  nps_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_in_job),
    .pop      (q_pop),
    .pop_job  (q_out_job),
    .stat     (q_stat)
  );

  nps_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .q_job    (q_out_job),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

### tb/nps_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nps_checker
// Watches the query, point and result channels of the nearest point search
// unit, tracks the nearest point of each set on its own and compares every
// result word with the prediction made when the set's last point went in.
// ----------------------------------------------------------------------------
module nps_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [nps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nps_pkg::COORD_W-1:0]   cfg_data,
  input  logic                          push,
  input  logic                          full,
  input  nps_pkg::in_word_t             in_data,
  input  logic                          empty,
  input  logic                          pop,
  input  nps_pkg::out_word_t            out_data,
  output int                            fail_count,
  output int                            results_due
);

  logic signed [nps_pkg::COORD_W-1:0] query_x;
  logic signed [nps_pkg::COORD_W-1:0] query_y;

  // running state of the open set
  logic [nps_pkg::DIST_W-1:0] best_sq;
  int                         best_pos;
  int                         points_in_set;
  logic                       set_overflow;

  nps_pkg::out_word_t due_results[$];

  function automatic logic [nps_pkg::DIST_W-1:0] squared_distance(
    logic signed [nps_pkg::COORD_W-1:0] px, logic signed [nps_pkg::COORD_W-1:0] py);
    longint dx;
    longint dy;
    dx = longint'(px) - longint'(query_x);
    dy = longint'(py) - longint'(query_y);
    return nps_pkg::DIST_W'(dx * dx + dy * dy);
  endfunction

  // distance with 8 fraction bits: largest r with r*r <= sq * 2^16
  function automatic logic [nps_pkg::ROOT_W-1:0] fixed_root(logic [nps_pkg::DIST_W-1:0] sq);
    longint unsigned radicand;
    longint unsigned trial;
    longint unsigned root;
    radicand = longint'(sq) << 16;
    root = 0;
    for (int b = nps_pkg::ROOT_W - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= radicand) root = trial;
    end
    return root[nps_pkg::ROOT_W-1:0];
  endfunction

  task automatic clear_set();
    best_sq = '0;
    best_pos = 0;
    points_in_set = 0;
    set_overflow = 1'b0;
  endtask

  task automatic track_point(nps_pkg::in_word_t pt);
    logic [nps_pkg::DIST_W-1:0] d;
    int                         pos;
    nps_pkg::out_word_t         res;
    d = squared_distance(pt.point_x, pt.point_y);
    // beyond capacity the position sticks at the last slot
    if (points_in_set >= nps_pkg::MAX_POINTS) begin
      set_overflow = 1'b1;
      pos = nps_pkg::MAX_POINTS - 1;
    end else begin
      pos = points_in_set;
    end
    if (points_in_set == 0 || d < best_sq) begin
      best_sq = d;
      best_pos = pos;
    end
    if (points_in_set < nps_pkg::MAX_POINTS) points_in_set++;
    if (pt.last_point) begin
      res.nearest_index = nps_pkg::IDX_W'(best_pos);
      res.nearest_distance = fixed_root(best_sq);
      res.count_overflow = set_overflow;
      due_results.push_back(res);
      clear_set();
    end
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    results_due = 0;
    query_x = '0;
    query_y = '0;
    clear_set();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      query_x = '0;
      query_y = '0;
      clear_set();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == nps_pkg::REG_QUERY_X) query_x = cfg_data;
        else if (cfg_index == nps_pkg::REG_QUERY_Y) query_y = cfg_data;
      end
      if (push && !full) track_point(in_data);
      if (pop && !empty) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result word, index %0d distance %0d overflow %0d",
                   $realtime, out_data.nearest_index, out_data.nearest_distance,
                   out_data.count_overflow);
          fail_count++;
        end else begin
          nps_pkg::out_word_t want;
          want = due_results.pop_front();
          check_field("nearest_index", want.nearest_index, out_data.nearest_index);
          check_field("nearest_distance", want.nearest_distance, out_data.nearest_distance);
          check_field("count_overflow", want.count_overflow, out_data.count_overflow);
        end
      end
      results_due = due_results.size();
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives point sets and query settings into the nearest point search unit:
// a directed opening of ties, extremes and single-point sets, a back-pressure
// burst, an over-capacity set and then random sets under random idling.
// ----------------------------------------------------------------------------
module testbench;

  localparam int RANDOM_POINTS = 750;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [nps_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [nps_pkg::COORD_W-1:0]   cfg_data;
  logic                          push;
  logic                          full;
  nps_pkg::in_word_t             in_data;
  logic                          empty;
  logic                          pop;
  nps_pkg::out_word_t            out_data;

  int fail_count;
  int results_due;

  // idling switches and the long receiver hold-off
  bit tx_idle;
  bit rx_idle;
  bit hold_rx;

  logic [nps_pkg::COORD_W-1:0] query_x_now;
  logic [nps_pkg::COORD_W-1:0] query_y_now;
  logic [nps_pkg::COORD_W-1:0] prev_x;
  logic [nps_pkg::COORD_W-1:0] prev_y;
  int                          random_points;
  int                          idle_cycles;

  nearest_point_search_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

  nps_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .full        (full),
    .in_data     (in_data),
    .empty       (empty),
    .pop         (pop),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("testbench failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // result side: random pop gaps, plus one long hold-off on request
  initial begin : result_drain
    int gap;
    pop = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_rx) begin
        gap = HOLD_CYCLES;
        hold_rx = 1'b0;
      end else begin
        gap = rx_idle ? $urandom_range(0, 17) : 0;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      @(negedge clk);
    end
  end

  task automatic push_point(input logic [nps_pkg::COORD_W-1:0] x,
                            input logic [nps_pkg::COORD_W-1:0] y, input logic last);
    int gap;
    gap = tx_idle ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= {x, y, last};
    push <= 1'b1;
    prev_x = x;
    prev_y = y;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [nps_pkg::CFG_IDX_W-1:0] idx,
                           input logic [nps_pkg::COORD_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // only called with the unit idle; writes to unused indexes must be ignored
  task automatic program_query(input logic [nps_pkg::COORD_W-1:0] x,
                               input logic [nps_pkg::COORD_W-1:0] y, input bit spare);
    logic [nps_pkg::CFG_IDX_W-1:0] spare_idx;
    write_reg(nps_pkg::REG_QUERY_X, x);
    if (spare) begin
      spare_idx = nps_pkg::CFG_IDX_W'(nps_pkg::REG_QUERY_Y + 1 + $urandom_range(0, 1));
      write_reg(spare_idx, 16'($urandom));
    end
    write_reg(nps_pkg::REG_QUERY_Y, y);
    cfg_valid <= 1'b0;
    query_x_now = x;
    query_y_now = y;
  endtask

  task automatic settle();
    push <= 1'b0;
    wait (results_due == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [nps_pkg::COORD_W-1:0] corner_coord();
    case ($urandom_range(0, 2))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return 16'h0000;
    endcase
  endfunction

  // mix of far points, points close to the query, repeats and corners
  task automatic send_random_set(input int n);
    logic [nps_pkg::COORD_W-1:0] x;
    logic [nps_pkg::COORD_W-1:0] y;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0, 1: begin
          x = 16'($urandom);
          y = 16'($urandom);
        end
        2, 3: begin
          x = query_x_now + 16'($urandom_range(0, 6)) - 16'd3;
          y = query_y_now + 16'($urandom_range(0, 6)) - 16'd3;
        end
        4: begin
          x = prev_x;
          y = prev_y;
        end
        default: begin
          x = corner_coord();
          y = corner_coord();
        end
      endcase
      push_point(x, y, i == n - 1);
      random_points++;
    end
  endtask

  initial begin
    int n;
    int phase_points;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = nps_pkg::REG_QUERY_X;
    cfg_data = '0;
    push = 1'b0;
    in_data = '0;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_rx = 1'b0;
    query_x_now = '0;
    query_y_now = '0;
    prev_x = '0;
    prev_y = '0;
    random_points = 0;
    idle_cycles = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // query at its reset value of the origin
    push_point(16'd0, 16'd0, 1'b1);
    push_point(16'd3, 16'd4, 1'b0);
    push_point(16'd3, 16'd4, 1'b0);
    push_point(-16'sd3, -16'sd4, 1'b0);
    push_point(16'd1, 16'd1, 1'b1);
    push_point(16'h8000, 16'h8000, 1'b0);
    push_point(16'h7fff, 16'h7fff, 1'b1);
    push_point(16'd5, 16'd0, 1'b0);
    push_point(16'd0, -16'sd5, 1'b0);
    push_point(16'd4, 16'd3, 1'b1);
    settle();

    // opposite corner gives the largest distance there is
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    program_query(16'h8000, 16'h8000, 1'b1);
    push_point(16'h7fff, 16'h7fff, 1'b1);
    push_point(16'h8000, 16'h8000, 1'b1);
    push_point(16'h7fff, 16'h8000, 1'b0);
    push_point(16'h8000, 16'h7fff, 1'b1);
    settle();

    // receiver holds off while single-point sets pile up behind full
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    program_query(16'h7fff, 16'h7fff, 1'b0);
    hold_rx = 1'b1;
    for (int i = 0; i < 24; i++) send_random_set(1);
    settle();

    // set longer than capacity, nearest point past the end
    program_query(16'($urandom), 16'($urandom), 1'b0);
    for (int i = 0; i < nps_pkg::MAX_POINTS; i++) begin
      push_point(query_x_now + 16'h4000 + 16'($urandom_range(0, 255)), 16'($urandom), 1'b0);
    end
    push_point(query_x_now, query_y_now, 1'b0);
    push_point(query_x_now, query_y_now, 1'b0);
    push_point(16'($urandom), 16'($urandom), 1'b1);
    settle();

    random_points = 0;
    while (random_points < RANDOM_POINTS) begin
      tx_idle = 1'($urandom_range(0, 1));
      rx_idle = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) program_query(corner_coord(), corner_coord(), 1'b1);
      else program_query(16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
      phase_points = 0;
      while (phase_points < 100 && random_points < RANDOM_POINTS) begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4);
        send_random_set(n);
        phase_points += n;
      end
      settle();
    end

    if (fail_count == 0 && results_due == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/nps_pkg.sv
hdl/nps_fifo.sv
hdl/nps_front.sv
hdl/nps_back.sv
hdl/nearest_point_search_unit.sv
tb/nps_checker.sv
tb/testbench.sv
